[rtl/png_scanline_unfilter_unit_defines.svh]
// Assertion macros for the port-level checker of the scanline unfilter unit.
`ifndef PNG_SCANLINE_UNFILTER_UNIT_DEFINES_SVH
`define PNG_SCANLINE_UNFILTER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define PSU_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: implication check failed");

// Next-cycle implication, disabled while reset is high.
`define PSU_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");

`endif

[rtl/psu_pkg.sv]
// Package: types, codes and constants of the PNG scanline unfilter unit.
package psu_pkg;

   localparam int MAX_WIDTH_DEF = 4096;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam int ROW_WIDTH_W = 13;
   localparam int FRAME_HEIGHT_W = 16;
   localparam int BPP_W = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_ROW_WIDTH       = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BYTES_PER_PIXEL = 2'd2;

   localparam logic [BPP_W-1:0] BPP_RGBA = 3'd4;

   localparam logic [2:0] FILT_NONE  = 3'd0;
   localparam logic [2:0] FILT_SUB   = 3'd1;
   localparam logic [2:0] FILT_UP    = 3'd2;
   localparam logic [2:0] FILT_AVG   = 3'd3;
   localparam logic [2:0] FILT_PAETH = 3'd4;

   localparam logic [1:0] CH_RED   = 2'd0;
   localparam logic [1:0] CH_BLUE  = 2'd2;
   localparam logic [1:0] CH_ALPHA = 2'd3;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       frame_start;
   } req_type;

   typedef struct packed {
      logic [7:0] pixel_value;
      logic [1:0] channel;
      logic       end_of_row;
      logic       end_of_frame;
      logic       bad_filter;
   } rsp_type;

   typedef enum logic [1:0] {
      OP_PIX   = 2'd0,
      OP_CLEAR = 2'd1,
      OP_ERR   = 2'd2
   } op_kind_type;

   // One word handed from the sequencer to the reconstruction stage.
   typedef struct packed {
      op_kind_type kind;
      logic [7:0]  data;
      logic [1:0]  ch;
      logic [2:0]  filt;
      logic        first_row;
      logic        eor;
      logic        eof;
   } stage_type;

endpackage

[rtl/psu_line_ram.sv]
// Line store: previous row's color bytes, one write and one registered read per cycle.
module psu_line_ram #(
   parameter int DEPTH  = 3 * psu_pkg::MAX_WIDTH_DEF,
   parameter int ADDR_W = $clog2(3 * psu_pkg::MAX_WIDTH_DEF)
) (
   input  logic              clock,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [7:0]        rd_data,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [7:0]        wr_data
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/psu_ctrl.sv]
// Sequencer: config registers, row/column/byte counters, filter byte decode, line store read.
module psu_ctrl #(
   parameter int MAX_WIDTH = psu_pkg::MAX_WIDTH_DEF,
   parameter int ADDR_W    = $clog2(3 * psu_pkg::MAX_WIDTH_DEF)
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  psu_pkg::req_type               req_data,
   input  logic                           csr_wr_en,
   input  logic [psu_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [psu_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  logic                           s1_go,
   output logic                           s1_valid,
   output psu_pkg::stage_type             s1_op,
   output logic [ADDR_W-1:0]              s1_addr,
   output logic                           rd_en,
   output logic [ADDR_W-1:0]              rd_addr
);

   localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int CMP_W = ((COL_W > psu_pkg::ROW_WIDTH_W) ? COL_W : psu_pkg::ROW_WIDTH_W) + 1;
   localparam int ROW_W = psu_pkg::FRAME_HEIGHT_W;

   logic [psu_pkg::ROW_WIDTH_W-1:0]    row_width_ff;
   logic [psu_pkg::FRAME_HEIGHT_W-1:0] frame_height_ff;
   logic [psu_pkg::BPP_W-1:0]          bpp_ff;

   logic [COL_W-1:0] col_ff, col_in;
   logic [1:0]       bip_ff, bip_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [2:0]       filt_ff, filt_in;
   logic             expect_ff, expect_in;
   logic             halted_ff, halted_in;

   logic                s1_valid_ff, s1_valid_in;
   psu_pkg::stage_type  s1_op_ff;
   logic [ADDR_W-1:0]   s1_addr_ff;

   logic               req_accept;
   logic               halted_e, expect_e;
   logic [ROW_W-1:0]   row_e;
   logic               last_col, last_row, last_byte;
   logic               op_valid;
   psu_pkg::stage_type op;
   logic [ADDR_W-1:0]  addr;

   assign req_ready  = !s1_valid_ff || s1_go;
   assign req_accept = req_valid && req_ready;

   always_comb begin
      halted_e = req_data.frame_start ? 1'b0 : halted_ff;
      expect_e = req_data.frame_start ? 1'b1 : expect_ff;
      row_e    = req_data.frame_start ? '0 : row_ff;

      last_col = ({{(CMP_W-COL_W){1'b0}}, col_ff} + CMP_W'(1)
                  >= {{(CMP_W-psu_pkg::ROW_WIDTH_W){1'b0}}, row_width_ff})
                 || (col_ff == COL_W'(MAX_WIDTH - 1));
      last_row = ({1'b0, row_e} + (ROW_W+1)'(1)) >= {1'b0, frame_height_ff};
      last_byte = (bip_ff == psu_pkg::CH_ALPHA)
                  || ((bpp_ff != psu_pkg::BPP_RGBA) && (bip_ff == psu_pkg::CH_BLUE));

      addr = (ADDR_W'(col_ff) << 1) + ADDR_W'(col_ff) + ADDR_W'(bip_ff);

      halted_in = halted_ff;
      expect_in = expect_ff;
      row_in    = row_ff;
      col_in    = col_ff;
      bip_in    = bip_ff;
      filt_in   = filt_ff;

      op_valid     = 1'b0;
      op.kind      = psu_pkg::OP_PIX;
      op.data      = req_data.data_byte;
      op.ch        = bip_ff;
      op.filt      = filt_ff;
      op.first_row = (row_e == '0);
      op.eor       = 1'b0;
      op.eof       = 1'b0;

      if (req_accept) begin
         halted_in = halted_e;
         expect_in = expect_e;
         row_in    = row_e;
         if (!halted_e) begin
            if (expect_e) begin
               op_valid = 1'b1;
               if (req_data.data_byte > {5'd0, psu_pkg::FILT_PAETH}) begin
                  op.kind   = psu_pkg::OP_ERR;
                  halted_in = 1'b1;
               end else begin
                  op.kind   = psu_pkg::OP_CLEAR;
                  filt_in   = req_data.data_byte[2:0];
                  expect_in = 1'b0;
                  col_in    = '0;
                  bip_in    = '0;
               end
            end else begin
               if (bip_ff != psu_pkg::CH_ALPHA) begin
                  op_valid = 1'b1;
                  op.eor   = (bip_ff == psu_pkg::CH_BLUE) && last_col;
                  op.eof   = (bip_ff == psu_pkg::CH_BLUE) && last_col && last_row;
               end
               if (last_byte) begin
                  bip_in = '0;
                  if (last_col) begin
                     col_in    = '0;
                     expect_in = 1'b1;
                     row_in    = last_row ? '0 : row_e + ROW_W'(1);
                  end else begin
                     col_in = col_ff + COL_W'(1);
                  end
               end else begin
                  bip_in = bip_ff + 2'd1;
               end
            end
         end
      end

      if (req_accept) begin
         s1_valid_in = op_valid;
      end else if (s1_go) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   assign rd_en   = req_accept && op_valid && (op.kind == psu_pkg::OP_PIX);
   assign rd_addr = addr;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_width_ff    <= psu_pkg::ROW_WIDTH_W'(1);
         frame_height_ff <= psu_pkg::FRAME_HEIGHT_W'(1);
         bpp_ff          <= psu_pkg::BPP_W'(3);
         col_ff          <= '0;
         bip_ff          <= '0;
         row_ff          <= '0;
         filt_ff         <= psu_pkg::FILT_NONE;
         expect_ff       <= 1'b1;
         halted_ff       <= 1'b0;
         s1_valid_ff     <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               psu_pkg::CSR_ROW_WIDTH: begin
                  row_width_ff <= csr_wdata[psu_pkg::ROW_WIDTH_W-1:0];
               end
               psu_pkg::CSR_FRAME_HEIGHT: begin
                  frame_height_ff <= csr_wdata[psu_pkg::FRAME_HEIGHT_W-1:0];
               end
               psu_pkg::CSR_BYTES_PER_PIXEL: begin
                  bpp_ff <= csr_wdata[psu_pkg::BPP_W-1:0];
               end
               default: begin
               end
            endcase
         end
         col_ff      <= col_in;
         bip_ff      <= bip_in;
         row_ff      <= row_in;
         filt_ff     <= filt_in;
         expect_ff   <= expect_in;
         halted_ff   <= halted_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_op_ff   <= op;
         s1_addr_ff <= addr;
      end
   end

   assign s1_valid = s1_valid_ff;
   assign s1_op    = s1_op_ff;
   assign s1_addr  = s1_addr_ff;

endmodule

[rtl/psu_recon.sv]
// Reconstruction stage: predictor (Sub/Up/Average/Paeth), neighbor registers, output register.
module psu_recon #(
   parameter int ADDR_W = $clog2(3 * psu_pkg::MAX_WIDTH_DEF)
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               s1_valid,
   input  psu_pkg::stage_type s1_op,
   input  logic [ADDR_W-1:0]  s1_addr,
   output logic               s1_go,
   input  logic [7:0]         above_byte,
   output logic               wr_en,
   output logic [ADDR_W-1:0]  wr_addr,
   output logic [7:0]         wr_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output psu_pkg::rsp_type   rsp_data
);

   logic [2:0][7:0]  left_ff, left_in;
   logic [2:0][7:0]  ul_ff, ul_in;
   logic             out_valid_ff, out_valid_in;
   psu_pkg::rsp_type out_ff;
   psu_pkg::rsp_type out_in;

   logic              has_result, step;
   logic [7:0]        a, b, c, pred, recon;
   logic [8:0]        ab_sum;
   logic signed [9:0] da, db, dc;
   logic [9:0]        pa, pb, pc;

   assign has_result = s1_valid && (s1_op.kind != psu_pkg::OP_CLEAR);
   assign s1_go      = !has_result || !out_valid_ff || rsp_ready;
   assign step       = s1_valid && s1_go;

   always_comb begin
      a = left_ff[s1_op.ch];
      c = ul_ff[s1_op.ch];
      b = s1_op.first_row ? 8'd0 : above_byte;

      ab_sum = {1'b0, a} + {1'b0, b};
      da = $signed({2'b00, b}) - $signed({2'b00, c});
      db = $signed({2'b00, a}) - $signed({2'b00, c});
      dc = $signed({2'b00, a}) + $signed({2'b00, b}) - $signed({1'b0, c, 1'b0});
      pa = da[9] ? 10'(-da) : 10'(da);
      pb = db[9] ? 10'(-db) : 10'(db);
      pc = dc[9] ? 10'(-dc) : 10'(dc);

      case (s1_op.filt)
         psu_pkg::FILT_SUB: pred = a;
         psu_pkg::FILT_UP:  pred = b;
         psu_pkg::FILT_AVG: pred = ab_sum[8:1];
         psu_pkg::FILT_PAETH: begin
            if ((pa <= pb) && (pa <= pc)) begin
               pred = a;
            end else if (pb <= pc) begin
               pred = b;
            end else begin
               pred = c;
            end
         end
         default: pred = 8'd0;
      endcase
      recon = s1_op.data + pred;

      left_in = left_ff;
      ul_in   = ul_ff;
      out_in  = out_ff;
      wr_en   = 1'b0;

      if (step) begin
         case (s1_op.kind)
            psu_pkg::OP_PIX: begin
               wr_en                = 1'b1;
               left_in[s1_op.ch]    = recon;
               ul_in[s1_op.ch]      = b;
               out_in.pixel_value   = recon;
               out_in.channel       = s1_op.ch;
               out_in.end_of_row    = s1_op.eor;
               out_in.end_of_frame  = s1_op.eof;
               out_in.bad_filter    = 1'b0;
            end
            psu_pkg::OP_CLEAR: begin
               left_in = '0;
               ul_in   = '0;
            end
            psu_pkg::OP_ERR: begin
               out_in.pixel_value  = 8'd0;
               out_in.channel      = psu_pkg::CH_RED;
               out_in.end_of_row   = 1'b0;
               out_in.end_of_frame = 1'b0;
               out_in.bad_filter   = 1'b1;
            end
            default: begin
            end
         endcase
      end

      if (step && has_result) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         left_ff      <= '0;
         ul_ff        <= '0;
      end else begin
         out_valid_ff <= out_valid_in;
         left_ff      <= left_in;
         ul_ff        <= ul_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign wr_addr   = s1_addr;
   assign wr_data   = recon;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

[rtl/png_scanline_unfilter_unit.sv]
// PNG scanline unfilter unit: one inflated stream byte in per cycle while req_ready
// is high, one reconstructed R, G or B byte out per color sample. Filter and alpha
// bytes give no word; a filter type above 4 gives one error word and input is
// dropped until the next frame_start. The line store is read when a byte is accepted
// and written when it leaves the stage register; a result word passes the stage
// register and then the output register. req_ready falls only while the output
// register holds an untaken word and the reconstruction stage has another one.
// Configure row_width, frame_height and bytes_per_pixel only while idle. The line
// store holds 3*MAX_WIDTH bytes and needs no clearing after reset.
module png_scanline_unfilter_unit #(
   parameter int MAX_WIDTH = psu_pkg::MAX_WIDTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  psu_pkg::req_type               req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output psu_pkg::rsp_type               rsp_data,
   input  logic                           csr_wr_en,
   input  logic [psu_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [psu_pkg::CSR_DATA_W-1:0] csr_wdata
);

   localparam int DEPTH  = 3 * MAX_WIDTH;
   localparam int ADDR_W = $clog2(DEPTH);

   logic               s1_go, s1_valid;
   psu_pkg::stage_type s1_op;
   logic [ADDR_W-1:0]  s1_addr;
   logic               rd_en, wr_en;
   logic [ADDR_W-1:0]  rd_addr, wr_addr;
   logic [7:0]         rd_data, wr_data;

   psu_ctrl #(
      .MAX_WIDTH (MAX_WIDTH),
      .ADDR_W    (ADDR_W)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .s1_go     (s1_go),
      .s1_valid  (s1_valid),
      .s1_op     (s1_op),
      .s1_addr   (s1_addr),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr)
   );

   psu_line_ram #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_line_ram (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   psu_recon #(
      .ADDR_W (ADDR_W)
   ) u_recon (
      .clock      (clock),
      .reset      (reset),
      .s1_valid   (s1_valid),
      .s1_op      (s1_op),
      .s1_addr    (s1_addr),
      .s1_go      (s1_go),
      .above_byte (rd_data),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule

[rtl/psu_checker.sv]
// Port-level checker for the scanline unfilter unit, bound to the top level.
`include "png_scanline_unfilter_unit_defines.svh"

module psu_checker (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input psu_pkg::rsp_type rsp_data
);

   logic err_word, err_fields_zero;
   logic eof_word, eor_word, eor_on_blue;
   logic rsp_stall, rsp_held;

   assign err_word        = rsp_valid && rsp_data.bad_filter;
   assign err_fields_zero = (rsp_data.pixel_value == 8'd0)
                            && (rsp_data.channel == psu_pkg::CH_RED)
                            && !rsp_data.end_of_row && !rsp_data.end_of_frame;
   assign eof_word        = rsp_valid && rsp_data.end_of_frame;
   assign eor_word        = rsp_valid && rsp_data.end_of_row;
   assign eor_on_blue     = (rsp_data.channel == psu_pkg::CH_BLUE) && !rsp_data.bad_filter;
   assign rsp_stall       = rsp_valid && !rsp_ready;

   `PSU_ASSERT_IMPL(a_err_word_clean, clock, reset, err_word, err_fields_zero)
   `PSU_ASSERT_IMPL(a_eof_is_eor, clock, reset, eof_word, rsp_data.end_of_row)
   `PSU_ASSERT_IMPL(a_eor_on_blue, clock, reset, eor_word, eor_on_blue)
   `PSU_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid && $stable(rsp_data))

endmodule

bind png_scanline_unfilter_unit psu_checker u_psu_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
